// ===== src/ffcr_pkg.sv =====
package ffcr_pkg;

	localparam int REQ_W          = 2;
	localparam int VERTEX_W       = 6;
	localparam int ROW_W          = 64;
	localparam int COLOR_W        = 16;
	localparam int VERTICES_DEF   = 64;
	localparam logic [COLOR_W-1:0] MAX_COLORS_RST = 16'd65;

	// Width of the free-color search window and of the chunk tested per cycle.
	localparam int CHUNK_W = 8;

	localparam logic [REQ_W-1:0] REQ_LOAD_ROW  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET_COLOR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RECOLOR   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_SCAN,
		ST_DRAIN,
		ST_SEARCH,
		ST_CHECK,
		ST_DIV,
		ST_COMMIT
	} ffcr_state_t;

	typedef struct packed {
		logic accept;
		logic load_row;
		logic scan;
		logic search;
		logic check;
		logic commit;
	} ffcr_cmd_t;

	typedef struct packed {
		logic recolor_req;
		logic scan_last;
		logic found;
		logic need_div;
		logic div_done;
		logic out_free;
	} ffcr_status_t;

endpackage

// ===== src/ffcr_mod.sv =====
// Restoring remainder unit: one quotient bit per cycle.
module ffcr_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ffcr_pkg::COLOR_W-1:0]  dividend,
	input  logic [ffcr_pkg::COLOR_W-1:0]  divisor,
	output logic                          done,
	output logic [ffcr_pkg::COLOR_W-1:0]  remainder
);

	localparam int W   = ffcr_pkg::COLOR_W;
	localparam int CNW = $clog2(W);
	localparam logic [CNW-1:0] LAST_STEP = CNW'(W - 1);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [W-1:0]   num_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   div_q;
	logic [W:0]     trial;
	logic [W-1:0]   rem_next;

	always_comb begin
		trial = {rem_q, num_q[W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = W'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== src/ffcr_dp.sv =====
module ffcr_dp #(
	parameter int VERTICES = ffcr_pkg::VERTICES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffcr_pkg::ffcr_cmd_t            cmd,
	output ffcr_pkg::ffcr_status_t         status,
	input  logic                           cfg_wr_en,
	input  logic [ffcr_pkg::COLOR_W-1:0]   cfg_wr_data,
	input  logic [ffcr_pkg::REQ_W-1:0]     req_type,
	input  logic [ffcr_pkg::VERTEX_W-1:0]  vertex,
	input  logic [ffcr_pkg::ROW_W-1:0]     row_bits,
	input  logic [ffcr_pkg::COLOR_W-1:0]   color_value,
	input  logic [ffcr_pkg::COLOR_W-1:0]   random_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ffcr_pkg::COLOR_W-1:0]   new_color
);

	localparam int CW    = ffcr_pkg::COLOR_W;
	localparam int VW    = ffcr_pkg::VERTEX_W;
	localparam int CH    = ffcr_pkg::CHUNK_W;
	localparam int IW    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	// Taken map holds colors 1..VERTICES; the zero pad above them makes the
	// search always end, at VERTICES+1 when every color is taken.
	localparam int TW    = ((VERTICES + CH) / CH) * CH;
	localparam int TIW   = $clog2(TW);
	localparam int NW    = $clog2(TW + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(VERTICES - 1);

	logic [VERTICES-1:0] adj_mem [VERTICES];
	logic [CW-1:0]       color_mem [VERTICES];

	logic [CW-1:0]       max_q;
	logic [IW-1:0]       v_q;
	logic [CW-1:0]       rnd_q;
	logic [VERTICES-1:0] adj_rd_q;
	logic [VERTICES-1:0] row_q;
	logic [IW-1:0]       j_q;
	logic [CW-1:0]       color_rd_q;
	logic                bit_s1;
	logic                vld_s1;
	logic [TW-1:0]       taken_q;
	logic [NW-1:0]       base_q;
	logic [NW-1:0]       cand_q;
	logic [CW-1:0]       res_q;
	logic                out_valid_q;
	logic [CW-1:0]       out_color_q;

	logic                vertex_ok;
	logic [IW-1:0]       in_idx;
	logic                color_we;
	logic [IW-1:0]       color_wa;
	logic [CW-1:0]       color_wd;
	logic                hit;
	logic [CW-1:0]       hit_idx;
	logic [CH-1:0]       chunk;
	logic [$clog2(CH)-1:0] enc;
	logic                need_rand;
	logic                tiny;
	logic                mod_start;
	logic                mod_done;
	logic [CW-1:0]       mod_rem;

	assign vertex_ok = ({1'b0, vertex} < (VW + 1)'(VERTICES));
	assign in_idx    = vertex[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= ffcr_pkg::MAX_COLORS_RST;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	// Adjacency memory: loads write at the item's vertex, a recolor reads its row.
	always_ff @(posedge clk) begin
		if (cmd.accept && vertex_ok && req_type == ffcr_pkg::REQ_LOAD_ROW) begin
			adj_mem[in_idx] <= row_bits[VERTICES-1:0];
		end
		if (cmd.accept) begin
			adj_rd_q <= adj_mem[in_idx];
		end
	end

	always_comb begin
		if (cmd.commit) begin
			color_we = 1'b1;
			color_wa = v_q;
			color_wd = res_q;
		end else begin
			color_we = cmd.accept && vertex_ok && req_type == ffcr_pkg::REQ_SET_COLOR;
			color_wa = in_idx;
			color_wd = color_value;
		end
	end

	always_ff @(posedge clk) begin
		if (color_we) begin
			color_mem[color_wa] <= color_wd;
		end
		if (cmd.scan) begin
			color_rd_q <= color_mem[j_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q   <= in_idx;
			rnd_q <= random_word;
		end
		if (cmd.load_row) begin
			row_q <= adj_rd_q;
			j_q   <= '0;
		end else if (cmd.scan) begin
			row_q <= row_q >> 1;
			j_q   <= j_q + 1'b1;
		end
		bit_s1 <= row_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
		end
	end

	// A neighbor's color marks its slot in the taken map in the cycle after the read.
	assign hit     = vld_s1 && bit_s1 && color_rd_q >= CW'(1)
		&& color_rd_q <= CW'(VERTICES);
	assign hit_idx = color_rd_q - CW'(1);

	assign chunk = taken_q[CH-1:0];

	always_comb begin
		enc = '0;
		for (int k = CH - 1; k >= 0; k--) begin
			if (!chunk[k]) begin
				enc = ($clog2(CH))'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			taken_q <= '0;
			base_q  <= '0;
		end else if (cmd.search) begin
			if (&chunk) begin
				taken_q <= taken_q >> CH;
				base_q  <= base_q + NW'(CH);
			end else begin
				cand_q <= base_q + NW'(enc) + NW'(1);
			end
		end else if (hit) begin
			taken_q[hit_idx[TIW-1:0]] <= 1'b1;
		end
	end

	assign need_rand = (CW'(cand_q) >= max_q);
	assign tiny      = (max_q <= CW'(1));
	assign mod_start = cmd.check && need_rand && !tiny;

	ffcr_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (rnd_q),
		.divisor   (max_q - CW'(1)),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			res_q <= tiny && need_rand ? CW'(1) : CW'(cand_q);
		end else if (mod_done) begin
			res_q <= mod_rem + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_color_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign new_color = out_color_q;

	assign status.recolor_req = vertex_ok && req_type == ffcr_pkg::REQ_RECOLOR;
	assign status.scan_last   = (j_q == LAST_IDX);
	assign status.found       = !(&chunk);
	assign status.need_div    = need_rand && !tiny;
	assign status.div_done    = mod_done;
	assign status.out_free    = !out_valid_q || out_ready;

endmodule

// ===== src/ffcr_ctrl.sv =====
module ffcr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ffcr_pkg::ffcr_status_t  status,
	output ffcr_pkg::ffcr_cmd_t     cmd
);

	ffcr_pkg::ffcr_state_t state_q;
	ffcr_pkg::ffcr_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ffcr_pkg::ST_IDLE: begin
				if (in_valid && status.recolor_req) begin
					state_next = ffcr_pkg::ST_ROW;
				end
			end
			ffcr_pkg::ST_ROW:   state_next = ffcr_pkg::ST_SCAN;
			ffcr_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_next = ffcr_pkg::ST_DRAIN;
				end
			end
			ffcr_pkg::ST_DRAIN: state_next = ffcr_pkg::ST_SEARCH;
			ffcr_pkg::ST_SEARCH: begin
				if (status.found) begin
					state_next = ffcr_pkg::ST_CHECK;
				end
			end
			ffcr_pkg::ST_CHECK: begin
				state_next = status.need_div ? ffcr_pkg::ST_DIV : ffcr_pkg::ST_COMMIT;
			end
			ffcr_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_next = ffcr_pkg::ST_COMMIT;
				end
			end
			ffcr_pkg::ST_COMMIT: begin
				if (status.out_free) begin
					state_next = ffcr_pkg::ST_IDLE;
				end
			end
			default: state_next = ffcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ffcr_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ffcr_pkg::ST_ROW:    cmd.load_row = 1'b1;
			ffcr_pkg::ST_SCAN:   cmd.scan     = 1'b1;
			ffcr_pkg::ST_SEARCH: cmd.search   = 1'b1;
			ffcr_pkg::ST_CHECK:  cmd.check    = 1'b1;
			ffcr_pkg::ST_COMMIT: cmd.commit   = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ===== src/first_free_color_recolor_unit.sv =====
// Channel   Direction  Handshake             Payload
// in        sink       in_valid/in_ready     req_type vertex row_bits color_value random_word
// out       source     out_valid/out_ready   new_color
// cfg       sink       cfg_wr_en             cfg_wr_data (max_colors)
//
// Load and color-write items are done on acceptance and leave the unit ready. A recolor
// reads the adjacency row, scans the color memory with one read per cycle, then
// searches one 8-color chunk per cycle; when the random fallback is used the
// 16-step remainder unit runs before the write-back.
// Reset clears control state and sets max_colors to 65; memories are not cleared.
// A finished color waits in the output register; a second recolor stalls at its
// write-back until that register has been taken.
module first_free_color_recolor_unit #(
	parameter int VERTICES = ffcr_pkg::VERTICES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ffcr_pkg::REQ_W-1:0]     req_type,
	input  logic [ffcr_pkg::VERTEX_W-1:0]  vertex,
	input  logic [ffcr_pkg::ROW_W-1:0]     row_bits,
	input  logic [ffcr_pkg::COLOR_W-1:0]   color_value,
	input  logic [ffcr_pkg::COLOR_W-1:0]   random_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ffcr_pkg::COLOR_W-1:0]   new_color,
	input  logic                           cfg_wr_en,
	input  logic [ffcr_pkg::COLOR_W-1:0]   cfg_wr_data
);

	ffcr_pkg::ffcr_cmd_t    cmd;
	ffcr_pkg::ffcr_status_t status;

	ffcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ffcr_dp #(
		.VERTICES (VERTICES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.vertex      (vertex),
		.row_bits    (row_bits),
		.color_value (color_value),
		.random_word (random_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.new_color   (new_color)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int NV             = ffcr_pkg::VERTICES_DEF;
	localparam int REQ_W          = ffcr_pkg::REQ_W;
	localparam int VERTEX_W       = ffcr_pkg::VERTEX_W;
	localparam int ROW_W          = ffcr_pkg::ROW_W;
	localparam int COLOR_W        = ffcr_pkg::COLOR_W;
	localparam int SETTLE_CYCLES  = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 164;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	class recolor_scoreboard;
		logic [NV-1:0]      adj [NV];
		logic [COLOR_W-1:0] colors [NV];
		logic [COLOR_W-1:0] limit;
		logic [COLOR_W-1:0] expected_colors [$];
		int unsigned        errors;
		int unsigned        recolors;
		int unsigned        fallbacks;

		function new();
			foreach (adj[i]) begin
				adj[i] = '0;
				colors[i] = '0;
			end
			limit = ffcr_pkg::MAX_COLORS_RST;
			errors = 0;
			recolors = 0;
			fallbacks = 0;
		endfunction

		function int unsigned pending();
			return expected_colors.size();
		endfunction

		// Smallest color from 1 up that no neighbor holds, with the random
		// fallback once that color reaches the limit.
		function logic [COLOR_W-1:0] first_fit_color(int unsigned v,
		                                             logic [COLOR_W-1:0] rnd);
			bit [NV+1:0] taken;
			int unsigned cand;
			int unsigned lim;
			int unsigned r;
			taken = '0;
			lim = limit;
			r = rnd;
			for (int j = 0; j < NV; j++) begin
				if (adj[v][j] && colors[j] >= 1 && colors[j] <= NV + 1)
					taken[colors[j]] = 1'b1;
			end
			cand = 1;
			while (cand <= NV && taken[cand])
				cand++;
			if (cand < lim)
				return COLOR_W'(cand);
			fallbacks++;
			if (lim <= 1)
				return COLOR_W'(1);
			return COLOR_W'(r % (lim - 1) + 1);
		endfunction

		function void note_item(logic [REQ_W-1:0] req, int unsigned v, logic [NV-1:0] row,
		                        logic [COLOR_W-1:0] col, logic [COLOR_W-1:0] rnd);
			logic [COLOR_W-1:0] nc;
			case (req)
			ffcr_pkg::REQ_LOAD_ROW: adj[v] = row;
			ffcr_pkg::REQ_SET_COLOR: colors[v] = col;
			ffcr_pkg::REQ_RECOLOR: begin
				nc = first_fit_color(v, rnd);
				colors[v] = nc;
				expected_colors.push_back(nc);
				recolors++;
			end
			default: ;
			endcase
		endfunction

		function void check_color(logic [COLOR_W-1:0] got);
			logic [COLOR_W-1:0] exp_color;
			if (expected_colors.size() == 0) begin
				$error("new_color %0d arrived with no recolor outstanding", got);
				errors++;
				return;
			end
			exp_color = expected_colors.pop_front();
			if (got !== exp_color) begin
				$error("new_color mismatch: expected %0d, actual %0d", exp_color, got);
				errors++;
			end
		endfunction

		function void finish_check();
			if (expected_colors.size() != 0) begin
				$error("new_color: %0d expected values never arrived", expected_colors.size());
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [REQ_W-1:0]   req_type;
	logic [VERTEX_W-1:0] vertex;
	logic [ROW_W-1:0]   row_bits;
	logic [COLOR_W-1:0] color_value;
	logic [COLOR_W-1:0] random_word;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COLOR_W-1:0] new_color;
	logic               cfg_wr_en;
	logic [COLOR_W-1:0] cfg_wr_data;

	recolor_scoreboard sb;

	// Which adjacency rows and vertex colors hold defined data so far.
	logic [NV-1:0] row_done;
	logic [NV-1:0] color_done;

	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned items_sent;
	int unsigned limit_writes;
	int unsigned idle_cycles;

	first_free_color_recolor_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.vertex      (vertex),
		.row_bits    (row_bits),
		.color_value (color_value),
		.random_word (random_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.new_color   (new_color),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_color(new_color);
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic send_item(input logic [REQ_W-1:0] rq, input int unsigned v,
	                         input logic [ROW_W-1:0] row, input logic [COLOR_W-1:0] col,
	                         input logic [COLOR_W-1:0] rnd);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		vertex <= VERTEX_W'(v);
		row_bits <= row;
		color_value <= col;
		random_word <= rnd;
		do @(posedge clk); while (!in_ready);
		sb.note_item(rq, v, row, col, rnd);
		items_sent++;
		case (rq)
		ffcr_pkg::REQ_LOAD_ROW: row_done[v] = 1'b1;
		ffcr_pkg::REQ_SET_COLOR, ffcr_pkg::REQ_RECOLOR: color_done[v] = 1'b1;
		default: ;
		endcase
	endtask

	// Sender holds off until every recolor has returned, then the block gets
	// time to finish any trailing load.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [COLOR_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.limit = value;
		limit_writes++;
	endtask

	function automatic logic [ROW_W-1:0] pick_row();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(5))
		0: return '0;
		1: return '1;
		2: return a;
		3: return a & b & {$urandom, $urandom};
		4: return a | b;
		default: return a & color_done;
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		else if (pick < 45)
			return COLOR_W'($urandom_range(1, 8));
		else if (pick < 80)
			return COLOR_W'($urandom_range(1, NV + 2));
		else if (pick < 95)
			return COLOR_W'($urandom);
		return '1;
	endfunction

	function automatic logic [COLOR_W-1:0] pick_random_word();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		default: return COLOR_W'($urandom);
		endcase
	endfunction

	// A recolor may only touch rows and neighbor colors that were written.
	// When no vertex qualifies, the item fills in what is missing instead.
	task automatic random_recolor();
		int unsigned start;
		int unsigned v;
		int unsigned m;
		bit found;
		logic [NV-1:0] missing;
		start = $urandom_range(NV - 1);
		found = 1'b0;
		v = start;
		for (int k = 0; k < NV && !found; k++) begin
			v = (start + k) % NV;
			if (row_done[v] && (sb.adj[v] & ~color_done) == '0)
				found = 1'b1;
		end
		if (found) begin
			send_item(ffcr_pkg::REQ_RECOLOR, v, {$urandom, $urandom}, COLOR_W'($urandom),
			          pick_random_word());
		end else if (row_done == '0) begin
			send_item(ffcr_pkg::REQ_LOAD_ROW, start, {$urandom, $urandom} & color_done,
			          COLOR_W'($urandom), COLOR_W'($urandom));
		end else begin
			for (int k = 0; k < NV && !found; k++) begin
				v = (start + k) % NV;
				if (row_done[v])
					found = 1'b1;
			end
			missing = sb.adj[v] & ~color_done;
			m = 0;
			while (!missing[m])
				m++;
			send_item(ffcr_pkg::REQ_SET_COLOR, m, {$urandom, $urandom}, pick_color_value(),
			          COLOR_W'($urandom));
		end
	endtask

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			send_item(REQ_UNUSED, $urandom_range(NV - 1), {$urandom, $urandom},
			          COLOR_W'($urandom), COLOR_W'($urandom));
		else if (pick < 25)
			send_item(ffcr_pkg::REQ_LOAD_ROW, $urandom_range(NV - 1), pick_row(),
			          COLOR_W'($urandom), COLOR_W'($urandom));
		else if (pick < 50)
			send_item(ffcr_pkg::REQ_SET_COLOR, $urandom_range(NV - 1), {$urandom, $urandom},
			          pick_color_value(), COLOR_W'($urandom));
		else
			random_recolor();
	endtask

	// Every vertex gets a distinct color in 1..NV, so a full row leaves
	// the first-fit search with nothing free below NV+1.
	task automatic color_ladder();
		int unsigned base;
		int unsigned v;
		logic [ROW_W-1:0] row;
		base = $urandom_range(NV - 1);
		for (int j = 0; j < NV; j++)
			send_item(ffcr_pkg::REQ_SET_COLOR, j, {$urandom, $urandom},
			          COLOR_W'((j + base) % NV + 1), COLOR_W'($urandom));
		for (int k = 0; k < 3; k++) begin
			v = $urandom_range(NV - 1);
			row = '1;
			if ($urandom_range(1))
				row[$urandom_range(NV - 1)] = 1'b0;
			send_item(ffcr_pkg::REQ_LOAD_ROW, v, row, COLOR_W'($urandom), COLOR_W'($urandom));
			send_item(ffcr_pkg::REQ_RECOLOR, v, {$urandom, $urandom}, COLOR_W'($urandom),
			          pick_random_word());
		end
	endtask

	task automatic directed_checks();
		// Reset limit of 65 is left in place for the first group.
		send_item(ffcr_pkg::REQ_LOAD_ROW, 0, '0, '1, '1);
		send_item(ffcr_pkg::REQ_SET_COLOR, 0, '1, '1, '1);
		send_item(ffcr_pkg::REQ_RECOLOR, 0, '1, '0, '0);
		send_item(ffcr_pkg::REQ_LOAD_ROW, 1, 64'h3, '0, '0);
		send_item(ffcr_pkg::REQ_SET_COLOR, 1, '0, '0, '0);
		send_item(ffcr_pkg::REQ_RECOLOR, 1, '0, '1, '1);
		send_item(ffcr_pkg::REQ_LOAD_ROW, NV - 1, 64'h8000_0000_0000_0003, '0, '0);
		send_item(ffcr_pkg::REQ_SET_COLOR, NV - 1, '0, '1, '0);
		send_item(ffcr_pkg::REQ_RECOLOR, NV - 1, '0, '0, '1);
		send_item(REQ_UNUSED, NV - 1, '1, '1, '1);
		send_item(REQ_UNUSED, 0, '0, '0, '0);
		send_item(ffcr_pkg::REQ_LOAD_ROW, 2, 64'h8000_0000_0000_0007, '0, '0);
		send_item(ffcr_pkg::REQ_SET_COLOR, 2, '0, COLOR_W'(3), '0);
		send_item(ffcr_pkg::REQ_RECOLOR, 2, '0, '0, '0);
		settle();
		// Limits of 1 and 0 always fall back to color 1.
		write_limit(COLOR_W'(1));
		send_item(ffcr_pkg::REQ_RECOLOR, 0, '0, '0, COLOR_W'($urandom));
		settle();
		write_limit('0);
		send_item(ffcr_pkg::REQ_RECOLOR, 1, '0, '0, '1);
		settle();
		write_limit(COLOR_W'(2));
		send_item(ffcr_pkg::REQ_RECOLOR, NV - 1, '0, '0, '1);
		settle();
		write_limit(COLOR_W'(3));
		send_item(ffcr_pkg::REQ_RECOLOR, 2, '0, '0, '1);
		send_item(ffcr_pkg::REQ_RECOLOR, NV - 1, '0, '0, '1);
		settle();
	endtask

	task automatic run_phase(input int unsigned s_idle, input int unsigned r_stall,
	                         input logic [COLOR_W-1:0] first_limit,
	                         input logic [COLOR_W-1:0] second_limit);
		sender_idle_pct = s_idle;
		receiver_stall_pct = r_stall;
		write_limit(first_limit);
		color_ladder();
		for (int i = 0; i < PHASE_ITEMS / 2; i++)
			random_item();
		settle();
		write_limit(second_limit);
		for (int i = 0; i < PHASE_ITEMS / 2; i++)
			random_item();
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = ffcr_pkg::REQ_LOAD_ROW;
		vertex = '0;
		row_bits = '0;
		color_value = '0;
		random_word = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		row_done = '0;
		color_done = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		items_sent = 0;
		limit_writes = 0;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_checks();
		run_phase(0, 0, '1, COLOR_W'(9));
		run_phase(73, 0, COLOR_W'(2), COLOR_W'(40));
		run_phase(0, 73, COLOR_W'($urandom_range(3, NV + 2)), COLOR_W'(NV));
		run_phase(25, 25, ffcr_pkg::MAX_COLORS_RST, COLOR_W'($urandom_range(2, 65535)));

		sb.finish_check();
		$display("Run covered %0d items with %0d recolors, %0d of them on the random fallback,",
		         items_sent, sb.recolors, sb.fallbacks);
		$display("over %0d color-limit writes and four sender/receiver stall patterns.",
		         limit_writes);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== first_free_color_recolor_unit.f =====
src/ffcr_pkg.sv
src/ffcr_mod.sv
src/ffcr_dp.sv
src/ffcr_ctrl.sv
src/first_free_color_recolor_unit.sv
sim/tb_top.sv
